/* src/priority_queue_linear_scan_assert.svh */
// Assertion macros for the priority queue block.
// Both sample on clk and stand down while rst_n is low.
`ifndef PRIORITY_QUEUE_LINEAR_SCAN_ASSERT_SVH
`define PRIORITY_QUEUE_LINEAR_SCAN_ASSERT_SVH

// Same-cycle implication.
`define PQLS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pqls check failed");

// Next-cycle implication.
`define PQLS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pqls check failed");

`endif

/* src/pqls_pkg.sv */
`timescale 1ns / 1ps

package pqls_pkg;

  localparam int ACT_W    = 2;
  localparam int PRIO_W   = 32;
  localparam int PAY_W    = 32;
  localparam int STAT_W   = 2;
  localparam int CNT_O_W  = 5;

  localparam logic [ACT_W-1:0] ACT_ADD    = 2'd0;
  localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_PEEK   = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SWAP,
    S_FINISH
  } state_t;

  // Control from the sequencer to the shared compare unit.
  typedef struct packed {
    logic step;   // a candidate entry is on the read port
    logic first;  // candidate is entry zero: take it unconditionally
  } scan_ctl_t;

endpackage

/* src/pqls_ifs.sv */
`timescale 1ns / 1ps

interface pqls_in_if import pqls_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ACT_W-1:0]  action;
  logic [PRIO_W-1:0] priority_req;
  logic [PAY_W-1:0]  payload;

  modport source (output valid, output action, output priority_req, output payload,
                  input ready);
  modport sink   (input valid, input action, input priority_req, input payload,
                  output ready);
endinterface

interface pqls_out_if import pqls_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [STAT_W-1:0]  status;
  logic [PRIO_W-1:0]  out_priority;
  logic [PAY_W-1:0]   out_payload;
  logic               is_empty;
  logic [CNT_O_W-1:0] entry_count;

  modport source (output valid, output status, output out_priority, output out_payload,
                  output is_empty, output entry_count, input ready);
  modport sink   (input valid, input status, input out_priority, input out_payload,
                  input is_empty, input entry_count, output ready);
endinterface

/* src/pqls_ram.sv */
`timescale 1ns / 1ps

module pqls_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

/* src/pqls_best.sv */
`timescale 1ns / 1ps

// Shared compare unit: keep the highest-priority entry seen so far.
module pqls_best import pqls_pkg::*; #(
  parameter int DEPTH        = 16,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic                             clk,
  input  scan_ctl_t                        ctl,
  input  logic [PRIO_W+PAYLOAD_BITS-1:0]   cand_entry,
  input  logic [$clog2(DEPTH)-1:0]         cand_idx,
  output logic [PRIO_W+PAYLOAD_BITS-1:0]   best_entry,
  output logic [$clog2(DEPTH)-1:0]         best_idx
);

  localparam int EW = PRIO_W + PAYLOAD_BITS;
  localparam int IW = $clog2(DEPTH);

  logic [EW-1:0] best_entry_r;
  logic [IW-1:0] best_idx_r;
  logic          take;

  // Strictly greater only, so the lowest index keeps a tie.
  always_comb begin
    take = ctl.step &&
           (ctl.first ||
            ($signed(cand_entry[EW-1 -: PRIO_W]) > $signed(best_entry_r[EW-1 -: PRIO_W])));
  end

  always_ff @(posedge clk) begin
    if (take) begin
      best_entry_r <= cand_entry;
      best_idx_r   <= cand_idx;
    end
  end

  assign best_entry = best_entry_r;
  assign best_idx   = best_idx_r;

endmodule

/* src/priority_queue_linear_scan.sv */
// Add, full/empty errors and unknown actions go from accept to the finish state and then
// the output register; peek and remove scan the entries held first, and remove then swaps.
// One request at a time: the next is taken once the result is registered, and the finish
// state holds while the output register is full. The store is scanned one entry a cycle.
// Reset (rst_n low, synchronous) empties the queue and drops any pending result;
// the entry store itself is not cleared and needs no clearing pass.
`timescale 1ns / 1ps

`include "priority_queue_linear_scan_assert.svh"

module priority_queue_linear_scan import pqls_pkg::*; #(
  parameter int DEPTH        = 16,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  pqls_in_if.sink    in_req,
  pqls_out_if.source out_res
);

  localparam int IW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int EW   = PRIO_W + PAYLOAD_BITS;
  localparam int KEEP = (PAYLOAD_BITS < PAY_W) ? PAYLOAD_BITS : PAY_W;

  // Sequencer state
  state_t            state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [IW-1:0]     k_r, k_nxt;          // index of the entry on the read port
  logic [ACT_W-1:0]  act_r, act_nxt;
  logic [STAT_W-1:0] res_status_r, res_status_nxt;
  logic [EW-1:0]     last_r, last_nxt;    // last entry, moved into the freed slot

  // Output register
  logic               out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0]  out_status_r, out_status_nxt;
  logic [PRIO_W-1:0]  out_prio_r, out_prio_nxt;
  logic [PAY_W-1:0]   out_pay_r, out_pay_nxt;
  logic               out_empty_r, out_empty_nxt;
  logic [CNT_O_W-1:0] out_count_r, out_count_nxt;

  // Store and compare unit
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic [EW-1:0] wr_data;
  logic [IW-1:0] rd_addr;
  logic [EW-1:0] rd_data;
  logic [EW-1:0] best_entry;
  logic [IW-1:0] best_idx;
  scan_ctl_t     scan_ctl;

  logic          accept;
  logic [IW-1:0] last_idx;
  logic          full;
  logic          emit;
  logic          add_go;

  assign accept   = in_req.valid && in_req.ready;
  assign last_idx = IW'(count_r - 1'b1);
  assign full     = (count_r == CW'(DEPTH));
  assign add_go   = accept && (in_req.action == ACT_ADD) && !full;
  assign in_req.ready = (state_r == S_IDLE);

  pqls_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  pqls_best #(
    .DEPTH        (DEPTH),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_best (
    .clk        (clk),
    .ctl        (scan_ctl),
    .cand_entry (rd_data),
    .cand_idx   (k_r),
    .best_entry (best_entry),
    .best_idx   (best_idx)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r          <= k_nxt;
    act_r        <= act_nxt;
    res_status_r <= res_status_nxt;
    last_r       <= last_nxt;
    out_status_r <= out_status_nxt;
    out_prio_r   <= out_prio_nxt;
    out_pay_r    <= out_pay_nxt;
    out_empty_r  <= out_empty_nxt;
    out_count_r  <= out_count_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    k_nxt          = k_r;
    act_nxt        = act_r;
    res_status_nxt = res_status_r;
    last_nxt       = last_r;
    wr_en          = 1'b0;
    wr_addr        = last_idx;
    wr_data        = {in_req.priority_req, PAYLOAD_BITS'(in_req.payload[KEEP-1:0])};
    rd_addr        = '0;
    scan_ctl       = '0;
    emit           = 1'b0;

    case (state_r)
      S_IDLE: begin
        // Start the read of entry zero in case this request scans.
        k_nxt = '0;
        if (accept) begin
          act_nxt        = in_req.action;
          res_status_nxt = STAT_OK;
          state_nxt      = S_FINISH;
          case (in_req.action)
            ACT_ADD: begin
              if (full) begin
                res_status_nxt = STAT_FULL;
              end else begin
                // Append at the end of the array.
                wr_en     = 1'b1;
                wr_addr   = IW'(count_r);
                count_nxt = count_r + 1'b1;
              end
            end
            ACT_REMOVE, ACT_PEEK: begin
              if (count_r == '0) begin
                res_status_nxt = STAT_EMPTY;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            default: begin
              // Unknown action: drop it, report ok with no entry.
              res_status_nxt = STAT_OK;
            end
          endcase
        end
      end

      S_SCAN: begin
        // One entry a cycle through the shared comparator.
        scan_ctl.step  = 1'b1;
        scan_ctl.first = (k_r == '0);
        rd_addr        = k_r + 1'b1;
        k_nxt          = k_r + 1'b1;
        if (k_r == last_idx) begin
          last_nxt  = rd_data;
          state_nxt = (act_r == ACT_REMOVE) ? S_SWAP : S_FINISH;
        end
      end

      S_SWAP: begin
        // Move the last entry into the freed slot and shrink.
        wr_en     = 1'b1;
        wr_addr   = best_idx;
        wr_data   = last_r;
        count_nxt = count_r - 1'b1;
        state_nxt = S_FINISH;
      end

      S_FINISH: begin
        // Hold here until the output register is free.
        if (!out_valid_r || out_res.ready) begin
          emit      = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output register: load on emit, clear when taken.
  always_comb begin
    out_valid_nxt  = out_valid_r && !out_res.ready;
    out_status_nxt = out_status_r;
    out_prio_nxt   = out_prio_r;
    out_pay_nxt    = out_pay_r;
    out_empty_nxt  = out_empty_r;
    out_count_nxt  = out_count_r;
    if (emit) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = res_status_r;
      out_empty_nxt  = (count_r == '0);
      out_count_nxt  = CNT_O_W'(count_r);
      if ((res_status_r == STAT_OK) && ((act_r == ACT_REMOVE) || (act_r == ACT_PEEK))) begin
        out_prio_nxt = best_entry[EW-1 -: PRIO_W];
        out_pay_nxt  = PAY_W'(best_entry[KEEP-1:0]);
      end else begin
        out_prio_nxt = '0;
        out_pay_nxt  = '0;
      end
    end
  end

  assign out_res.valid        = out_valid_r;
  assign out_res.status       = out_status_r;
  assign out_res.out_priority = out_prio_r;
  assign out_res.out_payload  = out_pay_r;
  assign out_res.is_empty     = out_empty_r;
  assign out_res.entry_count  = out_count_r;

  `PQLS_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CW'(DEPTH))
  `PQLS_ASSERT_NOW(a_scan_in_range, state_r == S_SCAN, (count_r != '0) && (k_r < count_r))
  `PQLS_ASSERT_NEXT(a_add_grows, add_go, count_r == $past(count_r) + 1'b1)
  `PQLS_ASSERT_NEXT(a_swap_shrinks, state_r == S_SWAP, count_r == $past(count_r) - 1'b1)

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps

// Testbench for the unsorted-array priority queue.
// Requests go in on one valid/ready channel and every request gives exactly
// one result. A behavioural queue kept here is updated as each request is
// accepted. The outcome it gives is queued and compared, field by field, with
// the results in the order they leave the block. Both sides idle at random,
// and a long receiver hold-off fills the block and stalls its input. The last
// part of the run streams with no idling on either side.

module tb;
  import pqls_pkg::*;

  localparam int DEPTH           = 16;
  localparam int PAYLOAD_BITS    = 32;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int SETTLE_CYCLES   = DEPTH + 8;
  localparam int REPORT_LIMIT    = 10;

  // The package names the three real actions; code 3 is taken and ignored.
  localparam logic [ACT_W-1:0] ACT_UNKNOWN = 2'd3;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [PRIO_W-1:0]  prio;
    logic [PAY_W-1:0]   pay;
    logic               empty;
    logic [CNT_O_W-1:0] count;
  } pq_outcome_t;

  logic clk = 1'b0;
  logic rst_n;

  pqls_in_if  in_req ();
  pqls_out_if out_res ();

  priority_queue_linear_scan #(
    .DEPTH        (DEPTH),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_res (out_res)
  );

  always #10 clk = ~clk;

  // Behavioural copy of the queue: entries below held_count are live.
  logic [PRIO_W-1:0] held_prio [DEPTH];
  logic [PAY_W-1:0]  held_pay  [DEPTH];
  int unsigned       held_count;

  // Outcomes of accepted requests, oldest first.
  pq_outcome_t pending_outcomes [$];

  int unsigned fault_count  = 0;
  int unsigned quiet_cycles = 0;
  int unsigned n_add = 0, n_remove = 0, n_peek = 0, n_unknown = 0;
  int unsigned n_full = 0, n_empty = 0, n_ties = 0, n_results = 0;

  // Idling controls shared by the two sides.
  bit source_gaps  = 1'b1;
  bit sink_stalls  = 1'b1;
  bit hold_off_req = 1'b0;

  // Apply one request to the queue copy and return what the block must report.
  function automatic pq_outcome_t apply_request(input logic [ACT_W-1:0]  act,
                                                input logic [PRIO_W-1:0] prio,
                                                input logic [PAY_W-1:0]  pay);
    pq_outcome_t o;
    int unsigned best;
    int unsigned top_hits;
    int unsigned i;
    o = '0;
    o.status = STAT_OK;
    case (act)
      ACT_ADD: begin
        n_add++;
        if (held_count >= DEPTH) begin
          // Full: reject and leave the store alone.
          o.status = STAT_FULL;
          n_full++;
        end else begin
          held_prio[held_count] = prio;
          held_pay[held_count]  = pay;
          held_count++;
        end
      end
      ACT_REMOVE, ACT_PEEK: begin
        if (act == ACT_REMOVE) n_remove++;
        else n_peek++;
        if (held_count == 0) begin
          o.status = STAT_EMPTY;
          n_empty++;
        end else begin
          // Linear scan; a strictly greater priority is needed to move on,
          // so the lowest index wins a tie.
          best     = 0;
          top_hits = 1;
          for (i = 1; i < held_count; i++) begin
            if ($signed(held_prio[i]) > $signed(held_prio[best])) begin
              best     = i;
              top_hits = 1;
            end else if (held_prio[i] == held_prio[best]) begin
              top_hits++;
            end
          end
          if (top_hits > 1) n_ties++;
          o.prio = held_prio[best];
          o.pay  = held_pay[best];
          if (act == ACT_REMOVE) begin
            // Move the last entry into the freed slot.
            held_prio[best] = held_prio[held_count - 1];
            held_pay[best]  = held_pay[held_count - 1];
            held_count--;
          end
        end
      end
      default: begin
        n_unknown++;
      end
    endcase
    o.empty = (held_count == 0);
    o.count = CNT_O_W'(held_count);
    return o;
  endfunction

  function automatic void report_fault(input string what, input pq_outcome_t want,
                                       input pq_outcome_t got);
    fault_count++;
    if (fault_count <= REPORT_LIMIT) begin
      $display("[%0t] %s", $realtime, what);
      $display("  expected status=%0d prio=%0d payload=%h empty=%0b count=%0d",
               want.status, $signed(want.prio), want.pay, want.empty, want.count);
      $display("  actual   status=%0d prio=%0d payload=%h empty=%0b count=%0d",
               got.status, $signed(got.prio), got.pay, got.empty, got.count);
    end
  endfunction

  // Check each result as it leaves the block against the oldest outcome.
  always @(posedge clk) begin
    pq_outcome_t got;
    pq_outcome_t want;
    string       bad;
    if (rst_n && out_res.valid && out_res.ready) begin
      got.status = out_res.status;
      got.prio   = out_res.out_priority;
      got.pay    = out_res.out_payload;
      got.empty  = out_res.is_empty;
      got.count  = out_res.entry_count;
      n_results++;
      if (pending_outcomes.size() == 0) begin
        report_fault("result with no request outstanding", '0, got);
      end else begin
        want = pending_outcomes.pop_front();
        bad  = "";
        if (got.status !== want.status) bad = {bad, " status"};
        if (got.prio   !== want.prio)   bad = {bad, " out_priority"};
        if (got.pay    !== want.pay)    bad = {bad, " out_payload"};
        if (got.empty  !== want.empty)  bad = {bad, " is_empty"};
        if (got.count  !== want.count)  bad = {bad, " entry_count"};
        if (bad != "") report_fault({"mismatch on", bad}, want, got);
      end
    end
  end

  // Watchdog: end the run if neither channel moves for too long.
  always @(posedge clk) begin
    if ((in_req.valid && in_req.ready) || (out_res.valid && out_res.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
               WATCHDOG_LIMIT, pending_outcomes.size());
      $display("priority_queue_linear_scan verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    out_res.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_res.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
        out_res.ready <= 1'b1;
      end else if (sink_stalls && $urandom_range(0, 9) == 0) begin
        out_res.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(negedge clk);
        out_res.ready <= 1'b1;
      end else begin
        out_res.ready <= 1'b1;
      end
    end
  end

  // Offer one request from a falling edge, hold it until accepted, record its
  // outcome, then maybe idle. Returns on a falling edge with valid left high
  // unless a gap was taken, so back-to-back requests never toggle valid.
  task automatic send_request(input logic [ACT_W-1:0]  act,
                              input logic [PRIO_W-1:0] prio,
                              input logic [PAY_W-1:0]  pay);
    pq_outcome_t outcome;
    in_req.valid        <= 1'b1;
    in_req.action       <= act;
    in_req.priority_req <= prio;
    in_req.payload      <= pay;
    do @(posedge clk); while (!in_req.ready);
    outcome          = apply_request(act, prio, pay);
    pending_outcomes = {pending_outcomes, outcome};
    @(negedge clk);
    if (source_gaps && $urandom_range(0, 5) == 0) begin
      in_req.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
  endtask

  // Priorities: extremes, a cluster around zero for ties, or anything at all.
  // The narrow mode keeps to a handful of values so ties are the norm.
  function automatic logic [PRIO_W-1:0] pick_priority(input bit narrow);
    case ($urandom_range(0, 7))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2, 3:    return PRIO_W'($urandom_range(0, 4) - 2);
      default: return narrow ? PRIO_W'($urandom_range(0, 2) - 1) : PRIO_W'($urandom());
    endcase
  endfunction

  function automatic logic [ACT_W-1:0] pick_action(input int unsigned add_w,
                                                   input int unsigned remove_w,
                                                   input int unsigned peek_w,
                                                   input int unsigned unknown_w);
    int unsigned r;
    r = $urandom_range(0, add_w + remove_w + peek_w + unknown_w - 1);
    if (r < add_w) return ACT_ADD;
    r -= add_w;
    if (r < remove_w) return ACT_REMOVE;
    r -= remove_w;
    if (r < peek_w) return ACT_PEEK;
    return ACT_UNKNOWN;
  endfunction

  task automatic send_random(input int unsigned add_w, input int unsigned remove_w,
                             input int unsigned peek_w, input int unsigned unknown_w,
                             input bit narrow);
    send_request(pick_action(add_w, remove_w, peek_w, unknown_w), pick_priority(narrow),
                 $urandom());
  endtask

  // Remove, peek and an unknown action on an empty queue.
  task automatic test_empty_errors();
    send_request(ACT_REMOVE, 32'h0000_0001, 32'h0000_0001);
    send_request(ACT_PEEK, 32'hffff_ffff, 32'hffff_ffff);
    send_request(ACT_UNKNOWN, 32'hffff_ffff, 32'hffff_ffff);
  endtask

  // Priority extremes, payload extremes and tie-breaking by lowest index.
  task automatic test_extremes_and_ties();
    send_request(ACT_ADD, 32'h7fff_ffff, 32'h0000_0000);
    send_request(ACT_ADD, 32'h8000_0000, 32'hffff_ffff);
    send_request(ACT_ADD, 32'h0000_0000, 32'h5a5a_5a5a);
    send_request(ACT_ADD, 32'h7fff_ffff, 32'ha5a5_a5a5);
    send_request(ACT_ADD, 32'hffff_ffff, 32'h0000_0001);
    // Two maxima held: the lower index must be served first.
    send_request(ACT_PEEK, '0, '0);
    send_request(ACT_REMOVE, '0, '0);
    // The last entry has been swapped into slot zero.
    send_request(ACT_PEEK, '0, '0);
    send_request(ACT_REMOVE, '0, '0);
    send_request(ACT_UNKNOWN, 32'h8000_0000, 32'h8000_0000);
    repeat (4) send_request(ACT_REMOVE, '0, '0);
  endtask

  // Fill to capacity, push past it, then drain below empty.
  task automatic test_fill_and_drain(input int unsigned rounds);
    repeat (rounds) begin
      while (held_count < DEPTH) begin
        if ($urandom_range(0, 7) == 0) send_request(ACT_PEEK, '0, '0);
        send_request(ACT_ADD, pick_priority(1'b0), $urandom());
      end
      repeat ($urandom_range(1, 3)) send_request(ACT_ADD, pick_priority(1'b0), $urandom());
      send_request(ACT_PEEK, '0, '0);
      while (held_count > 0) send_request(ACT_REMOVE, '0, '0);
      send_request(pick_action(0, 1, 1, 0), '0, '0);
    end
  endtask

  // Balanced mix: the fill level wanders between empty and full.
  task automatic test_random_mix(input int unsigned items);
    repeat (items) send_random(35, 35, 20, 5, 1'b0);
  endtask

  // Few distinct priorities so most scans meet equal maxima.
  task automatic test_tie_storm(input int unsigned items);
    repeat (items) send_random(45, 30, 20, 5, 1'b1);
  endtask

  // Hold the receiver off while requests keep coming; the block must stall.
  task automatic test_backpressure(input int unsigned items);
    hold_off_req = 1'b1;
    repeat (items) send_random(40, 35, 20, 5, 1'b0);
  endtask

  // Final stretch with both sides always willing.
  task automatic test_streaming(input int unsigned items);
    source_gaps = 1'b0;
    sink_stalls = 1'b0;
    repeat (items) send_random(35, 35, 20, 5, 1'b0);
  endtask

  initial begin
    rst_n               = 1'b0;
    in_req.valid        = 1'b0;
    in_req.action       = ACT_ADD;
    in_req.priority_req = '0;
    in_req.payload      = '0;
    held_count          = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_errors();
    test_extremes_and_ties();
    test_fill_and_drain(6);
    test_random_mix(400);
    test_tie_storm(200);
    test_backpressure(24);
    test_streaming(350);

    // Drop valid, drain what is outstanding, then let the block settle.
    in_req.valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    fault_count += pending_outcomes.size();

    $display("covered %0d adds, %0d removes, %0d peeks, %0d ignored actions; %0d results",
             n_add, n_remove, n_peek, n_unknown, n_results);
    $display("%0d full rejections, %0d empty rejections, %0d tied scans, %0d faults",
             n_full, n_empty, n_ties, fault_count);
    if (fault_count == 0) begin
      $display("priority_queue_linear_scan verification clean");
    end else begin
      $display("priority_queue_linear_scan verification failed");
    end
    $finish;
  end

endmodule
